// ----- hw/rtl/pwm_pdm_pkg.sv -----
// Shared types and constants of the PWM period and duty meter.
`default_nettype none

package pwm_pdm_pkg;

    // Default width of the tick counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Widths of the result fields
    localparam int MEAS_W = 16;
    localparam int DUTY_W = 7;
    localparam int SCALE_W = 24;

    // Shift-subtract divider: one quotient bit per step over the scale width
    localparam int DIV_STEPS = SCALE_W;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam int SUM_W = MEAS_W + 1;

    // Reset values of the configuration registers
    localparam logic FIRST_RISING_RST = 1'b1;
    localparam logic [SCALE_W-1:0] SCALE_RST = 24'd62000;

    // Controller states
    typedef enum logic [2:0] {
        S_MEASURE = 3'b001,
        S_DIVIDE  = 3'b010,
        S_EMIT    = 3'b100
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic sample;    // a level word is accepted this cycle
        logic div_step;  // advance both dividers by one bit
        logic out_load;  // load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic complete;  // the present level word closes a measurement
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/pwm_pdm_ctrl.sv -----
// Controller of the PWM meter: handshakes, divider sequencing, result register valid.
`default_nettype none

module pwm_pdm_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  pwm_pdm_pkg::t_status  i_status,
    output pwm_pdm_pkg::t_cmd     o_cmd
);

    pwm_pdm_pkg::t_state r_state, n_state;
    logic [pwm_pdm_pkg::STEP_W-1:0] r_step, n_step;
    logic r_out_valid, n_out_valid;
    logic accept;
    logic load;
    logic last_step;

    assign o_in_ready  = (r_state == pwm_pdm_pkg::S_MEASURE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign last_step   = (r_step == pwm_pdm_pkg::STEP_W'(pwm_pdm_pkg::DIV_STEPS - 1));
    assign load        = (r_state == pwm_pdm_pkg::S_EMIT) && (!r_out_valid || i_out_ready);

    // Drive datapath commands
    always_comb begin
        o_cmd.sample   = accept;
        o_cmd.div_step = (r_state == pwm_pdm_pkg::S_DIVIDE);
        o_cmd.out_load = load;
    end

    // Sequence measure, divide and emit
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            pwm_pdm_pkg::S_MEASURE: begin
                n_step = '0;
                if (accept && i_status.complete) begin
                    n_state = pwm_pdm_pkg::S_DIVIDE;
                end
            end
            pwm_pdm_pkg::S_DIVIDE: begin
                n_step = r_step + 1'b1;
                if (last_step) begin
                    n_state = pwm_pdm_pkg::S_EMIT;
                end
            end
            pwm_pdm_pkg::S_EMIT: begin
                if (load) begin
                    n_state = pwm_pdm_pkg::S_MEASURE;
                end
            end
            default: begin
                n_state = pwm_pdm_pkg::S_MEASURE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwm_pdm_pkg::S_MEASURE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // A completing word starts the divider
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_status.complete |=> r_state == pwm_pdm_pkg::S_DIVIDE)
        else $error("divider not started after completing word");

    // The last divider step leads to emit
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwm_pdm_pkg::S_DIVIDE) && last_step |=> r_state == pwm_pdm_pkg::S_EMIT)
        else $error("divider did not finish after its last step");

    // A blocked result keeps the controller waiting
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwm_pdm_pkg::S_EMIT) && r_out_valid && !i_out_ready
        |=> r_state == pwm_pdm_pkg::S_EMIT)
        else $error("result overwritten while still pending");

    // Loading a result shows it on the output
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("loaded result not marked valid");

endmodule

`default_nettype wire

// ----- hw/rtl/pwm_pdm_dp.sv -----
// Datapath of the PWM meter: tick counter, capture phases, dividers, result register.
`default_nettype none

module pwm_pdm_dp #(
    parameter int COUNT_WIDTH = pwm_pdm_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  pwm_pdm_pkg::t_cmd                    i_cmd,
    output pwm_pdm_pkg::t_status                 o_status,
    input  wire                                  i_level,
    input  wire                                  i_first_rising,
    input  wire  [pwm_pdm_pkg::SCALE_W-1:0]      i_scale,
    output logic [pwm_pdm_pkg::MEAS_W-1:0]       o_high,
    output logic [pwm_pdm_pkg::MEAS_W-1:0]       o_low,
    output logic [pwm_pdm_pkg::MEAS_W-1:0]       o_freq,
    output logic [pwm_pdm_pkg::DUTY_W-1:0]       o_duty
);

    localparam int MW = pwm_pdm_pkg::MEAS_W;
    localparam int SW = pwm_pdm_pkg::SCALE_W;
    localparam int UW = pwm_pdm_pkg::SUM_W;
    localparam int EXT_W = (COUNT_WIDTH > MW) ? COUNT_WIDTH : MW;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_OTHER  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // Measurement state
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [1:0] r_phase, n_phase;
    logic r_prev;
    logic [MW-1:0] r_high, n_high;
    logic [MW-1:0] r_low, n_low;

    // Divider state
    logic [UW-1:0] r_sum;
    logic [SW-1:0] r_fq, r_dq;
    logic [UW-1:0] r_fr, r_dr;

    // Result register
    logic [MW-1:0] r_out_high, r_out_low, r_out_freq;
    logic [pwm_pdm_pkg::DUTY_W-1:0] r_out_duty;

    logic edge_seen, first_kind, other_kind, complete;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [EXT_W-1:0] tick_ext;
    logic [MW-1:0] cap;
    logic [UW:0] f_trial, d_trial;
    logic f_ge, d_ge;

    // Classify the edge of this level word
    assign edge_seen  = (i_level != r_prev);
    assign first_kind = edge_seen && (i_level == i_first_rising);
    assign other_kind = edge_seen && (i_level != i_first_rising);
    assign complete   = (r_phase == PH_SECOND) && first_kind;
    assign o_status.complete = complete;

    // Advance the counter, saturating, and clip the capture to 16 bits
    assign tick_inc = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign tick_ext = EXT_W'(tick_inc);
    assign cap = (tick_ext > EXT_W'(17'h0FFFF)) ? '1 : tick_ext[MW-1:0];

    // Step the capture phases
    always_comb begin
        n_tick  = tick_inc;
        n_phase = r_phase;
        n_high  = r_high;
        n_low   = r_low;
        unique case (r_phase)
            PH_OTHER: begin
                if (other_kind) begin
                    if (i_first_rising) begin
                        n_high = cap;
                    end else begin
                        n_low = cap;
                    end
                    n_tick  = '0;
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (first_kind) begin
                    if (i_first_rising) begin
                        n_low = cap;
                    end else begin
                        n_high = cap;
                    end
                    n_phase = PH_FIRST;
                end
            end
            default: begin
                if (first_kind) begin
                    n_tick  = '0;
                    n_phase = PH_OTHER;
                end else begin
                    n_phase = PH_FIRST;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_phase <= PH_FIRST;
            r_prev  <= 1'b0;
            r_high  <= '0;
            r_low   <= '0;
        end else if (i_cmd.sample) begin
            r_tick  <= n_tick;
            r_phase <= n_phase;
            r_prev  <= i_level;
            r_high  <= n_high;
            r_low   <= n_low;
        end
    end

    // One restoring step for each quotient
    assign f_trial = {r_fr, r_fq[SW-1]};
    assign d_trial = {r_dr, r_dq[SW-1]};
    assign f_ge = (f_trial >= {1'b0, r_sum});
    assign d_ge = (d_trial >= {1'b0, r_sum});

    // Load operands on completion, then shift one bit a step
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample && complete) begin
            r_sum <= UW'(n_high) + UW'(n_low);
            r_fq  <= i_scale;
            r_dq  <= SW'(n_high) * SW'(7'd100);
            r_fr  <= '0;
            r_dr  <= '0;
        end else if (i_cmd.div_step) begin
            r_fr <= f_ge ? UW'(f_trial - {1'b0, r_sum}) : f_trial[UW-1:0];
            r_dr <= d_ge ? UW'(d_trial - {1'b0, r_sum}) : d_trial[UW-1:0];
            r_fq <= {r_fq[SW-2:0], f_ge};
            r_dq <= {r_dq[SW-2:0], d_ge};
        end
    end

    // Latch the result word, saturating frequency and guarding a zero period
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_high <= r_high;
            r_out_low  <= r_low;
            if (r_sum == '0) begin
                r_out_freq <= '1;
                r_out_duty <= '0;
            end else begin
                r_out_freq <= (r_fq > SW'(16'hFFFF)) ? '1 : r_fq[MW-1:0];
                r_out_duty <= r_dq[pwm_pdm_pkg::DUTY_W-1:0];
            end
        end
    end

    assign o_high = r_out_high;
    assign o_low  = r_out_low;
    assign o_freq = r_out_freq;
    assign o_duty = r_out_duty;

endmodule

`default_nettype wire

// ----- hw/rtl/pwm_period_duty_meter.sv -----
// Top level of the PWM period and duty meter: configuration registers and stream ports.
`default_nettype none

// Takes one sampled PWM level per word on the slave stream and times the high
// and low halves with a saturating tick counter and a three-phase edge
// sequencer (first edge, opposite edge, first edge again). A sample word is
// taken every cycle while measuring. The word that closes a measurement holds
// the input off through the 24 steps of the shift-subtract dividers that
// form frequency and duty one quotient bit per cycle, and through the load of
// the result register; the load, and with it the input, waits further while
// the previous result word has not been taken. The result word (high, low,
// frequency, duty) then waits in that register while sampling goes on. Only
// every other period is measured.
// Registers: 0x0 first_edge_rising, 0x4 frequency_scale.
module pwm_period_duty_meter #(
    parameter int COUNT_WIDTH = pwm_pdm_pkg::COUNT_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] level, [7:1] zero
    // Result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata    // [15:0] high_ticks, [31:16] low_ticks,
                                        // [47:32] frequency, [54:48] duty_percent,
                                        // [55] zero
);

    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    logic r_first_rising;
    logic [pwm_pdm_pkg::SCALE_W-1:0] r_scale;
    logic wr_en;

    pwm_pdm_pkg::t_cmd    cmd;
    pwm_pdm_pkg::t_status status;

    logic [pwm_pdm_pkg::MEAS_W-1:0] res_high, res_low, res_freq;
    logic [pwm_pdm_pkg::DUTY_W-1:0] res_duty;

    // Write configuration on the access cycle
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_rising <= pwm_pdm_pkg::FIRST_RISING_RST;
            r_scale        <= pwm_pdm_pkg::SCALE_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FIRST: r_first_rising <= pwdata[0];
                REG_SCALE: r_scale        <= pwdata[pwm_pdm_pkg::SCALE_W-1:0];
                default:   r_scale        <= r_scale;
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        unique case (paddr[2])
            REG_FIRST: prdata = {31'd0, r_first_rising};
            REG_SCALE: prdata = {8'd0, r_scale};
            default:   prdata = '0;
        endcase
    end

    pwm_pdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pwm_pdm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_level        (s_axis_tdata[0]),
        .i_first_rising (r_first_rising),
        .i_scale        (r_scale),
        .o_high         (res_high),
        .o_low          (res_low),
        .o_freq         (res_freq),
        .o_duty         (res_duty)
    );

    // Pack the result word
    assign m_axis_tdata = {1'b0, res_duty, res_freq, res_low, res_high};

endmodule

`default_nettype wire
